// File: hw/rtl/wjd_pkg.sv
// wjd_pkg: shared types and codes of the worker job dispatcher.
// Used by wjd_pend_fifo and worker_job_dispatcher_core; depends on nothing.
package wjd_pkg;

	localparam int JOB_W = 16;

	// event codes
	localparam logic [2:0] OP_ADD_JOB    = 3'd0;
	localparam logic [2:0] OP_CONNECT    = 3'd1;
	localparam logic [2:0] OP_WORK_MSG   = 3'd2;
	localparam logic [2:0] OP_RESULT     = 3'd3;
	localparam logic [2:0] OP_HEARTBEAT  = 3'd4;
	localparam logic [2:0] OP_DISCONNECT = 3'd5;
	localparam logic [2:0] OP_UNPARSABLE = 3'd6;

	// answer codes
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_EXIT = 2'd1;
	localparam logic [1:0] ACT_SEND = 2'd2;

	localparam logic [1:0] BEAT_MAX = 2'd3;

	// one entry of the per-worker memory
	typedef struct packed {
		logic [1:0]       beat;
		logic             valid;
		logic [JOB_W-1:0] job;
	} worker_rec_t;

	// requests from the event logic to the pending FIFO
	typedef struct packed {
		logic             push;
		logic             pop;
		logic [JOB_W-1:0] job;
	} fifo_cmd_t;

	// FIFO status; head_job is the registered read of the head entry
	typedef struct packed {
		logic             empty;
		logic             one;
		logic             full;
		logic [JOB_W-1:0] head_job;
	} fifo_stat_t;

endpackage

// File: hw/rtl/wjd_ram.sv
// wjd_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module wjd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/wjd_pend_fifo.sv
// wjd_pend_fifo: circular FIFO of pending job ids, storage in a wjd_ram.
// Depends on wjd_pkg and wjd_ram. The head entry is read when rd_en is high.
module wjd_pend_fifo #(
	parameter int DEPTH = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  wjd_pkg::fifo_cmd_t     cmd,
	output wjd_pkg::fifo_stat_t    stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0]             head_q;
	logic [AW-1:0]             tail_q;
	logic [CW-1:0]             count_q;
	logic [wjd_pkg::JOB_W-1:0] head_job;

	wjd_ram #(
		.WIDTH(wjd_pkg::JOB_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(tail_q),
		.wdata(cmd.job),
		.re   (rd_en),
		.raddr(head_q),
		.rdata(head_job)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
			end
			if (cmd.pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			count_q <= count_q + CW'(cmd.push) - CW'(cmd.pop);
		end
	end

	always_comb begin
		stat.empty    = (count_q == '0);
		stat.one      = (count_q == CW'(1));
		stat.full     = (count_q == CW'(DEPTH));
		stat.head_job = head_job;
	end

endmodule

// File: hw/rtl/worker_job_dispatcher_core.sv
// worker_job_dispatcher_core: top level; event decode and read-modify-write of
// the per-worker memory (beat count, slot valid, slot job) and the pending FIFO.
// Depends on wjd_pkg, wjd_ram and wjd_pend_fifo.
//
//   group  dir  tdata fields (lsb first)                          bits
//   s_*    in   op[2:0] worker[8:3] new_job[24:9] result_value[56:25]  64
//   m_*    out  action[1:0] sent_job[17:2] total[49:18]
//               all_done[50] dropped[51]                          56
//
// Each event has a read step and an update step: the accept edge reads the
// worker entry and the FIFO head, the update edge writes back and loads the
// output register. After reset a clearing pass zeroes every worker memory entry;
// s_tready stays low meanwhile.
// A result waiting in the output register holds the following event in its update
// cycle until m_tready; s_tready stays low until that event completes.
module worker_job_dispatcher_core #(
	parameter int MAX_JOBS    = 1024,
	parameter int MAX_WORKERS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // op, worker, new_job, result_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // action, sent_job, total, all_done, dropped
);

	localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int BW = $clog2(MAX_WORKERS + 1);

	logic accept;
	logic fire;

	// update stage
	logic                      v_s1;
	logic [2:0]                op_s1;
	logic [5:0]                worker_s1;
	logic [wjd_pkg::JOB_W-1:0] job_s1;
	logic [31:0]               rv_s1;

	logic          clr_q;
	logic [WW-1:0] clr_idx_q;
	logic [BW-1:0] busy_q;
	logic [31:0]   sum_q;
	logic          m_tvalid_q;
	logic [55:0]   m_tdata_q;

	wjd_pkg::worker_rec_t rec_rd;
	wjd_pkg::worker_rec_t rec_wr;
	wjd_pkg::fifo_cmd_t   fifo_cmd;
	wjd_pkg::fifo_stat_t  fifo_st;

	logic [$bits(wjd_pkg::worker_rec_t)-1:0] wk_rdata;
	logic [$bits(wjd_pkg::worker_rec_t)-1:0] wk_wdata;
	logic [WW-1:0]                           wk_waddr;
	logic                                    wk_we;

	logic [1:0]                act;
	logic [wjd_pkg::JOB_W-1:0] send_job;
	logic                      drop;
	logic                      push;
	logic                      pop;
	logic [wjd_pkg::JOB_W-1:0] push_job;
	logic                      rec_we;
	logic                      busy_inc;
	logic                      busy_dec;
	logic                      sum_add;
	logic                      done_now;
	logic                      w_ok;
	logic [1:0]                beat_inc;
	logic [BW-1:0]             busy_next;
	logic [31:0]               sum_next;
	logic                      empty_next;
	logic                      all_done;

	assign s_tready = !v_s1 && !clr_q;
	assign accept   = s_tvalid && s_tready;
	assign fire     = v_s1 && (!m_tvalid_q || m_tready);

	wjd_ram #(
		.WIDTH($bits(wjd_pkg::worker_rec_t)),
		.DEPTH(MAX_WORKERS)
	) u_worker_ram (
		.clk  (clk),
		.we   (wk_we),
		.waddr(wk_waddr),
		.wdata(wk_wdata),
		.re   (accept),
		.raddr(WW'(s_tdata[8:3])),
		.rdata(wk_rdata)
	);

	wjd_pend_fifo #(
		.DEPTH(MAX_JOBS)
	) u_pend_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.rd_en (accept),
		.cmd   (fifo_cmd),
		.stat  (fifo_st)
	);

	assign rec_rd = wjd_pkg::worker_rec_t'(wk_rdata);

	always_comb begin
		act      = wjd_pkg::ACT_NONE;
		send_job = '0;
		drop     = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		push_job = job_s1;
		rec_wr   = rec_rd;
		rec_we   = 1'b0;
		busy_inc = 1'b0;
		busy_dec = 1'b0;
		sum_add  = 1'b0;
		done_now = fifo_st.empty && (busy_q == '0);
		w_ok     = int'(worker_s1) < MAX_WORKERS;
		beat_inc = (rec_rd.beat == wjd_pkg::BEAT_MAX) ? wjd_pkg::BEAT_MAX
			: rec_rd.beat + 2'd1;
		if (op_s1 == wjd_pkg::OP_ADD_JOB) begin
			if (fifo_st.full) begin
				drop = 1'b1;
			end else begin
				push = 1'b1;
			end
		end else if (done_now) begin
			act = wjd_pkg::ACT_EXIT;
		end else if (w_ok) begin
			case (op_s1)
				wjd_pkg::OP_RESULT: begin
					sum_add      = 1'b1;
					rec_we       = 1'b1;
					rec_wr.valid = 1'b0;
					busy_dec     = rec_rd.valid;
					// freeing the last busy slot with nothing pending ends the work
					if (fifo_st.empty && rec_rd.valid && busy_q == BW'(1)) begin
						act = wjd_pkg::ACT_EXIT;
					end else if (!fifo_st.empty) begin
						act          = wjd_pkg::ACT_SEND;
						send_job     = fifo_st.head_job;
						pop          = 1'b1;
						rec_wr.valid = 1'b1;
						rec_wr.job   = fifo_st.head_job;
						busy_inc     = 1'b1;
					end
				end
				wjd_pkg::OP_HEARTBEAT: begin
					rec_we      = 1'b1;
					rec_wr.beat = beat_inc;
					if (beat_inc > 2'd1 && !fifo_st.empty && !rec_rd.valid) begin
						act          = wjd_pkg::ACT_SEND;
						send_job     = fifo_st.head_job;
						pop          = 1'b1;
						rec_wr.valid = 1'b1;
						rec_wr.job   = fifo_st.head_job;
						busy_inc     = 1'b1;
					end
				end
				wjd_pkg::OP_DISCONNECT: begin
					if (rec_rd.valid) begin
						rec_we       = 1'b1;
						rec_wr.valid = 1'b0;
						busy_dec     = 1'b1;
						push_job     = rec_rd.job;
						if (fifo_st.full) begin
							drop = 1'b1;
						end else begin
							push = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		fifo_cmd.push = fire && push;
		fifo_cmd.pop  = fire && pop;
		fifo_cmd.job  = push_job;
	end

	// clearing pass owns the write port; no event is in flight meanwhile
	assign wk_we    = clr_q || (fire && rec_we);
	assign wk_waddr = clr_q ? clr_idx_q : WW'(worker_s1);
	assign wk_wdata = clr_q ? '0 : rec_wr;

	assign busy_next  = busy_q + BW'(busy_inc) - BW'(busy_dec);
	assign sum_next   = sum_add ? sum_q + rv_s1 : sum_q;
	assign empty_next = (fifo_st.empty && !push) || (fifo_st.one && pop);
	assign all_done   = empty_next && (busy_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			clr_q      <= 1'b1;
			clr_idx_q  <= '0;
			busy_q     <= '0;
			sum_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				if (clr_idx_q == WW'(MAX_WORKERS - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + WW'(1);
				end
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (fire) begin
				busy_q     <= busy_next;
				sum_q      <= sum_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= s_tdata[2:0];
			worker_s1 <= s_tdata[8:3];
			job_s1    <= s_tdata[24:9];
			rv_s1     <= s_tdata[56:25];
		end
		if (fire) begin
			m_tdata_q <= {4'b0, drop, all_done, sum_next, send_job, act};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	// no new read may overlap the write-back of the event in flight
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !s_tready)
		else $error("event accepted during write-back");

	a_busy_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q <= BW'(MAX_WORKERS))
		else $error("busy count above worker count");

	a_fifo_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_cmd.push && fifo_cmd.pop))
		else $error("push and pop in one event");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cmd.push |-> !fifo_st.full)
		else $error("push into full FIFO");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("completed event produced no beat");
`endif

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for worker_job_dispatcher_core.
// Keeps its own job dispatch model, drives events with random gaps and checks every
// answer beat field by field. Depends on wjd_pkg and the dispatcher RTL.
module testbench;

	localparam int JOBS_DEPTH  = 1024;
	localparam int WORKERS     = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 50;
	localparam logic [2:0] OP_RESERVED = 3'd7;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] job;
		logic [31:0] total;
		logic        all_done;
		logic        dropped;
	} dispatch_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	bit stall_en = 1'b1;
	bit rx_hold = 1'b0;
	int err_cnt = 0;
	int cycle_cnt = 0;

	dispatch_answer_t answers_due[$];

	// model of the dispatcher state
	logic [15:0] pend_mem [JOBS_DEPTH];
	int unsigned pend_rd = 0;
	int unsigned pend_wr = 0;
	int unsigned pend_cnt = 0;
	bit          slot_busy [WORKERS];
	logic [15:0] slot_id [WORKERS];
	int unsigned busy_total = 0;
	logic [1:0]  beats [WORKERS];
	logic [31:0] sum_acc = '0;

	worker_job_dispatcher_core #(
		.MAX_JOBS(JOBS_DEPTH),
		.MAX_WORKERS(WORKERS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic bit jobs_idle();
		return pend_cnt == 0 && busy_total == 0;
	endfunction

	function automatic bit pend_push(input logic [15:0] job);
		if (pend_cnt >= JOBS_DEPTH)
			return 1'b0;
		pend_mem[pend_wr] = job;
		pend_wr = (pend_wr + 1) % JOBS_DEPTH;
		pend_cnt++;
		return 1'b1;
	endfunction

	function automatic bit try_assign(input int w, output logic [15:0] job);
		job = '0;
		if (pend_cnt == 0 || slot_busy[w])
			return 1'b0;
		job = pend_mem[pend_rd];
		pend_rd = (pend_rd + 1) % JOBS_DEPTH;
		pend_cnt--;
		slot_busy[w] = 1'b1;
		slot_id[w] = job;
		busy_total++;
		return 1'b1;
	endfunction

	function automatic void release_slot(input int w);
		if (slot_busy[w]) begin
			slot_busy[w] = 1'b0;
			busy_total--;
		end
	endfunction

	function automatic dispatch_answer_t dispatch_answer(input logic [2:0] op,
			input logic [5:0] wk, input logic [15:0] nj, input logic [31:0] rv);
		dispatch_answer_t a;
		logic [15:0] job;
		a = '0;
		job = '0;
		if (op == wjd_pkg::OP_ADD_JOB) begin
			a.dropped = !pend_push(nj);
		end else if (jobs_idle()) begin
			a.action = wjd_pkg::ACT_EXIT;
		end else begin
			case (op)
				wjd_pkg::OP_RESULT: begin
					sum_acc = sum_acc + rv;
					release_slot(wk);
					if (jobs_idle())
						a.action = wjd_pkg::ACT_EXIT;
					else if (try_assign(wk, job))
						a.action = wjd_pkg::ACT_SEND;
				end
				wjd_pkg::OP_HEARTBEAT: begin
					if (beats[wk] < wjd_pkg::BEAT_MAX)
						beats[wk]++;
					if (beats[wk] > 2'd1 && try_assign(wk, job))
						a.action = wjd_pkg::ACT_SEND;
				end
				wjd_pkg::OP_DISCONNECT: begin
					if (slot_busy[wk]) begin
						release_slot(wk);
						a.dropped = !pend_push(slot_id[wk]);
					end
				end
				default: ;
			endcase
		end
		if (a.action == wjd_pkg::ACT_SEND)
			a.job = job;
		a.total = sum_acc;
		a.all_done = jobs_idle();
		return a;
	endfunction

	task automatic report_mismatch(input string what);
		// print only the first few, keep counting
		if (err_cnt < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_cnt, what);
		err_cnt++;
	endtask

	// one event beat; leaves s_tvalid high so back-to-back beats need no toggle
	task automatic send_event(input logic [2:0] op, input logic [5:0] wk,
			input logic [15:0] nj, input logic [31:0] rv);
		if (stall_en) begin
			while ($urandom_range(99) < 34) begin
				s_tvalid = 1'b0;
				s_tdata = {$urandom, $urandom};
				@(negedge clk);
			end
		end
		s_tvalid = 1'b1;
		s_tdata = {7'b0, rv, nj, wk, op};
		do @(posedge clk); while (!s_tready);
		answers_due.insert(answers_due.size(), dispatch_answer(op, wk, nj, rv));
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (rx_hold)
			m_tready = 1'b0;
		else if (stall_en)
			m_tready = ($urandom_range(99) >= 34);
		else
			m_tready = 1'b1;
	end

	always @(posedge clk) begin
		dispatch_answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				report_mismatch("answer beat with nothing outstanding");
			end else begin
				want = answers_due[0];
				answers_due.delete(0);
				if (m_tdata[1:0] !== want.action)
					report_mismatch($sformatf("action %0d, want %0d",
						m_tdata[1:0], want.action));
				if (m_tdata[17:2] !== want.job)
					report_mismatch($sformatf("sent_job %h, want %h",
						m_tdata[17:2], want.job));
				if (m_tdata[49:18] !== want.total)
					report_mismatch($sformatf("total %h, want %h",
						m_tdata[49:18], want.total));
				if (m_tdata[50] !== want.all_done)
					report_mismatch($sformatf("all_done %b, want %b",
						m_tdata[50], want.all_done));
				if (m_tdata[51] !== want.dropped)
					report_mismatch($sformatf("dropped %b, want %b",
						m_tdata[51], want.dropped));
			end
		end
	end

	task automatic test_directed();
		// nothing pending: every non-add event answers exit, result not summed
		send_event(wjd_pkg::OP_CONNECT, 6'd0, 16'h0000, 32'h0);
		send_event(wjd_pkg::OP_UNPARSABLE, 6'd63, 16'hFFFF, 32'h0);
		send_event(OP_RESERVED, 6'd0, 16'h0, 32'h0);
		send_event(wjd_pkg::OP_RESULT, 6'd5, 16'h0, 32'hFFFF_FFFF);
		send_event(wjd_pkg::OP_ADD_JOB, 6'd0, 16'h0000, 32'h0);
		send_event(wjd_pkg::OP_ADD_JOB, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
		send_event(wjd_pkg::OP_ADD_JOB, 6'd9, 16'h1234, 32'h0);
		// first heartbeat only counts, second hands out
		send_event(wjd_pkg::OP_HEARTBEAT, 6'd0, 16'h0, 32'h0);
		send_event(wjd_pkg::OP_HEARTBEAT, 6'd0, 16'h0, 32'h0);
		send_event(wjd_pkg::OP_CONNECT, 6'd0, 16'h0, 32'h0);
		send_event(wjd_pkg::OP_WORK_MSG, 6'd0, 16'h0, 32'h0);
		send_event(wjd_pkg::OP_RESULT, 6'd0, 16'h0, 32'hFFFF_FFFF);
		// result from an idle worker: sum wraps, next job goes out
		send_event(wjd_pkg::OP_RESULT, 6'd1, 16'h0, 32'h0000_0002);
		send_event(wjd_pkg::OP_DISCONNECT, 6'd0, 16'h0, 32'h0);
		send_event(wjd_pkg::OP_DISCONNECT, 6'd2, 16'h0, 32'h0);
		// beat count saturates while the worker is busy
		repeat (4) send_event(wjd_pkg::OP_HEARTBEAT, 6'd63, 16'h0, 32'h0);
		send_event(wjd_pkg::OP_UNPARSABLE, 6'd63, 16'h0, 32'h0);
		send_event(OP_RESERVED, 6'd63, 16'h0, 32'h0);
		send_event(wjd_pkg::OP_RESULT, 6'd63, 16'h0, 32'h0);
		send_event(wjd_pkg::OP_RESULT, 6'd1, 16'h0, 32'h7FFF_FFFF);
		send_event(wjd_pkg::OP_HEARTBEAT, 6'd63, 16'h0, 32'h0);
	endtask

	task automatic test_random_mix(input int n_items);
		int pick;
		logic [2:0] op;
		logic [5:0] wk;
		logic [15:0] nj;
		logic [31:0] rv;
		repeat (n_items) begin
			pick = int'($urandom_range(99));
			if (pick < 18)      op = wjd_pkg::OP_ADD_JOB;
			else if (pick < 43) op = wjd_pkg::OP_HEARTBEAT;
			else if (pick < 68) op = wjd_pkg::OP_RESULT;
			else if (pick < 78) op = wjd_pkg::OP_DISCONNECT;
			else if (pick < 84) op = wjd_pkg::OP_CONNECT;
			else if (pick < 90) op = wjd_pkg::OP_WORK_MSG;
			else if (pick < 95) op = wjd_pkg::OP_UNPARSABLE;
			else                op = OP_RESERVED;
			// small pool so heartbeats pile up on the same workers
			wk = ($urandom_range(99) < 80) ? 6'($urandom_range(7))
				: 6'($urandom_range(63));
			case ($urandom_range(9))
				0: nj = 16'h0000;
				1: nj = 16'hFFFF;
				default: nj = 16'($urandom_range(65535));
			endcase
			case ($urandom_range(9))
				0: rv = 32'h0;
				1: rv = 32'hFFFF_FFFF;
				default: rv = $urandom;
			endcase
			send_event(op, wk, nj, rv);
		end
	endtask

	task automatic test_fill_and_drop();
		// worker 0 ends up holding a job
		send_event(wjd_pkg::OP_ADD_JOB, 6'd0, 16'($urandom_range(65535)), $urandom);
		send_event(wjd_pkg::OP_RESULT, 6'd0, 16'h0, 32'd1);
		fork
			begin
				@(posedge clk);
				rx_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		while (pend_cnt < JOBS_DEPTH)
			send_event(wjd_pkg::OP_ADD_JOB, 6'($urandom_range(63)),
				16'($urandom_range(65535)), $urandom);
		repeat (3)
			send_event(wjd_pkg::OP_ADD_JOB, 6'($urandom_range(63)),
				16'($urandom_range(65535)), $urandom);
		send_event(wjd_pkg::OP_DISCONNECT, 6'd0, 16'h0, 32'h0);
	endtask

	task automatic test_drain();
		int w;
		while (!jobs_idle()) begin
			if (pend_cnt != 0) begin
				w = int'($urandom_range(63));
			end else begin
				w = 0;
				while (!slot_busy[w])
					w++;
			end
			send_event(wjd_pkg::OP_RESULT, w[5:0], 16'($urandom_range(65535)), $urandom);
		end
		send_event(wjd_pkg::OP_HEARTBEAT, 6'd63, 16'h0, 32'h0);
	endtask

	initial begin
		foreach (beats[i])
			beats[i] = 2'd0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_mix(700);
		stall_en = 1'b0;
		test_random_mix(200);
		stall_en = 1'b1;
		test_random_mix(100);
		test_fill_and_drop();
		test_drain();
		s_tvalid = 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
